[sv/psir_pkg.sv]
// ----------------------------------------------------------------------------
// psir_pkg
// Shared types and constants of the particle splat image reconstructor.
// ----------------------------------------------------------------------------
package psir_pkg;

    localparam int IMAGE_SIZE    = 512;
    localparam int COORD_W       = $clog2(IMAGE_SIZE);
    localparam int PIX_AW        = 2 * COORD_W;
    localparam int MAX_PARTICLES = 256;
    localparam int PART_AW       = $clog2(MAX_PARTICLES);
    localparam int CNT_W         = PART_AW + 1;

    localparam int POS_W   = 16;
    localparam int PCO_W   = 20;   // particle coordinate, signed Q11.8
    localparam int SUM_W   = 24;   // pixel sum, Q8.16
    localparam int RAD_W   = 8;
    localparam int WIN_W   = 15;
    localparam int INT_W   = 16;

    // shared long divider: quotient bits resolved one per cycle
    localparam int DIV_Q_W   = 17;
    localparam int DIV_DEN_W = 24;
    localparam int DIV_NUM_W = DIV_DEN_W + DIV_Q_W;

    // square root unit: radicand Q.32, root Q.16
    localparam int SQ_ROOT_W = 24;
    localparam int SQ_RAD_W  = 2 * SQ_ROOT_W;

    localparam logic [RAD_W-1:0] RADIUS_RST = 8'd51;
    localparam logic [WIN_W-1:0] WINDOW_RST = 15'd6554;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_RENDER = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_FLAT     = 2'd2,
        ST_NOT_REND = 2'd3
    } t_status;

    typedef enum logic {
        CFG_RADIUS = 1'b0,
        CFG_WINDOW = 1'b1
    } t_cfg_idx;

endpackage

[sv/psir_div.sv]
// ----------------------------------------------------------------------------
// psir_div
// Restoring long divider, one quotient bit per cycle. The upper part of the
// dividend must be below the divisor so the quotient fits DIV_Q_W bits.
// ----------------------------------------------------------------------------
module psir_div
    import psir_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_done,
    output logic [DIV_Q_W-1:0]   o_quo
);

    localparam int CW = $clog2(DIV_Q_W);

    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_Q_W-1:0]   r_lo;
    logic [DIV_Q_W-1:0]   r_quo;
    logic [CW-1:0]        r_cnt;
    logic                 r_run;
    logic                 r_done;
    logic [DIV_DEN_W:0]   trial;
    logic                 take;

    assign trial = {r_rem, r_lo[DIV_Q_W-1]};
    assign take  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CW'(DIV_Q_W - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[DIV_NUM_W-1:DIV_Q_W];
            r_lo  <= i_num[DIV_Q_W-1:0];
            r_den <= i_den;
        end else if (r_run) begin
            r_rem <= take ? DIV_DEN_W'(trial - {1'b0, r_den}) : trial[DIV_DEN_W-1:0];
            r_lo  <= {r_lo[DIV_Q_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_Q_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[sv/psir_sqrt.sv]
// ----------------------------------------------------------------------------
// psir_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module psir_sqrt
    import psir_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [SQ_RAD_W-1:0]  i_rad,
    output logic                 o_done,
    output logic [SQ_ROOT_W-1:0] o_root
);

    localparam int CW    = $clog2(SQ_ROOT_W);
    localparam int REM_W = SQ_ROOT_W + 2;

    logic [SQ_RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]     r_rem;
    logic [SQ_ROOT_W-1:0] r_root;
    logic [CW-1:0]        r_cnt;
    logic                 r_run;
    logic                 r_done;
    logic [REM_W+1:0]     rem_sh;
    logic [REM_W+1:0]     trial;
    logic                 take;

    assign rem_sh = {r_rem, r_rad[SQ_RAD_W-1:SQ_RAD_W-2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= CW'(SQ_ROOT_W - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_run) begin
            r_rad  <= {r_rad[SQ_RAD_W-3:0], 2'b00};
            r_rem  <= take ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
            r_root <= {r_root[SQ_ROOT_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

[sv/particle_splat_image_reconstruct_top.sv]
// ----------------------------------------------------------------------------
// particle_splat_image_reconstruct_top
// Particle store, cone-kernel splat renderer over a pixel sum memory, and
// min/max normalized pixel readout.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  command  | start, busy               | i_cmd, i_pos_x/y, i_alive, i_pixel_*
//  result   | o_valid (one-cycle pulse) | o_status, o_intensity, o_min/max_sum
//  config   | i_cfg_valid, o_cfg_ready  | i_cfg_index, i_cfg_data
//
//  Add: a direct store, or inside the window two divides (x, then y).
//  Clear particles and error results: answered from idle. Read: divider.
//  Render: clear pass and min/max scan pass over every pixel, plus per stored
//  particle load, setup and advance; per visited pixel square, compare, step;
//  per covered pixel root, divide and pixel read-modify-write.
//  Reset is synchronous active low; the image memory needs no reset pass.
//  Each word is one command; one result word follows each; no output stall.
// ----------------------------------------------------------------------------
module particle_splat_image_reconstruct_top
    import psir_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_cmd,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic                     i_alive,
    input  logic [COORD_W-1:0]       i_pixel_col,
    input  logic [COORD_W-1:0]       i_pixel_row,
    output logic                     o_valid,
    output logic [1:0]               o_status,
    output logic [INT_W-1:0]         o_intensity,
    output logic [SUM_W-1:0]         o_min_sum,
    output logic [SUM_W-1:0]         o_max_sum,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic                     i_cfg_index,
    input  logic [WIN_W-1:0]         i_cfg_data
);

    typedef enum logic [16:0] {
        S_IDLE  = 17'b00000000000000001,
        S_DIVX  = 17'b00000000000000010,
        S_DIVY  = 17'b00000000000000100,
        S_CLEAR = 17'b00000000000001000,
        S_PLOAD = 17'b00000000000010000,
        S_PSET  = 17'b00000000000100000,
        S_SQ    = 17'b00000000001000000,
        S_CMP   = 17'b00000000010000000,
        S_SQRT  = 17'b00000000100000000,
        S_DIVC  = 17'b00000001000000000,
        S_PRD   = 17'b00000010000000000,
        S_STEP  = 17'b00000100000000000,
        S_NEXTP = 17'b00001000000000000,
        S_SCAN  = 17'b00010000000000000,
        S_SCANE = 17'b00100000000000000,
        S_RDW   = 17'b01000000000000000,
        S_RDDIV = 17'b10000000000000000
    } t_state;

    localparam int PW  = 2 * PCO_W + 1;
    localparam int BW  = COORD_W + 5;   // signed window bound
    localparam int DW  = PCO_W + 1;     // signed pixel-centre offset
    localparam int D2W = 2 * DW;

    t_state               r_state;
    logic [RAD_W-1:0]     r_radius;
    logic [WIN_W-1:0]     r_window;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_i;
    logic                 r_rendered;
    logic [SUM_W-1:0]     r_min;
    logic [SUM_W-1:0]     r_max;
    logic                 r_valid;
    logic [1:0]           r_status;
    logic [INT_W-1:0]     r_intensity;

    logic signed [POS_W-1:0] r_py;
    logic                 r_alive;
    logic [DIV_Q_W-1:0]   r_qx;
    logic [PIX_AW-1:0]    r_addr;
    logic                 r_scan_v;

    logic signed [PCO_W-1:0] r_px_c;
    logic signed [PCO_W-1:0] r_py_c;
    logic [COORD_W-1:0]   r_x;
    logic [COORD_W-1:0]   r_y;
    logic [COORD_W-1:0]   r_x0;
    logic [COORD_W-1:0]   r_x1;
    logic [COORD_W-1:0]   r_y1;
    logic [D2W-1:0]       r_dx2;
    logic [D2W-1:0]       r_dy2;
    logic [DIV_Q_W-1:0]   r_add;

    // memories
    logic [PW-1:0]        m_part [0:MAX_PARTICLES-1];
    logic [SUM_W-1:0]     m_pix  [0:(1 << PIX_AW)-1];
    logic [PW-1:0]        r_part_q;
    logic [SUM_W-1:0]     r_pix_q;
    logic                 part_we;
    logic [PW-1:0]        part_wdata;
    logic                 pix_we;
    logic [PIX_AW-1:0]    pix_waddr;
    logic [SUM_W-1:0]     pix_wdata;
    logic [PIX_AW-1:0]    pix_raddr;

    // arithmetic units
    logic                 div_start;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_Q_W-1:0]   div_quo;
    logic                 sq_start;
    logic [SQ_RAD_W-1:0]  sq_rad;
    logic                 sq_done;
    logic [SQ_ROOT_W-1:0] sq_root;

    logic                 accept;
    logic                 full;
    logic signed [POS_W:0] ws;
    logic signed [POS_W:0] xs;
    logic signed [POS_W:0] ys;
    logic                 in_win;
    logic signed [POS_W:0] xsum;
    logic signed [POS_W:0] ysum;
    logic [PCO_W-1:0]     x_out;
    logic [PCO_W-1:0]     y_out;
    logic [PCO_W-1:0]     qy_ext;
    logic [PCO_W-1:0]     qx_ext;

    logic signed [PCO_W-1:0] pd_x;
    logic signed [PCO_W-1:0] pd_y;
    logic                 pd_alive;
    logic signed [BW-1:0] cxs;
    logic signed [BW-1:0] cys;
    logic signed [BW-1:0] rs;
    logic signed [BW-1:0] x0s;
    logic signed [BW-1:0] x1s;
    logic signed [BW-1:0] y0s;
    logic signed [BW-1:0] y1s;
    logic signed [BW-1:0] x0c;
    logic signed [BW-1:0] x1c;
    logic signed [BW-1:0] y0c;
    logic signed [BW-1:0] y1c;
    logic                 empty;

    logic signed [DW-1:0]  dx;
    logic signed [DW-1:0]  dy;
    logic signed [D2W-1:0] dx2;
    logic signed [D2W-1:0] dy2;
    logic [D2W:0]          d2;
    logic [2*RAD_W-1:0]    rsq;
    logic [D2W:0]          lim;
    logic                  in_range;
    logic [SUM_W:0]        acc;
    logic [SUM_W-1:0]      acc_sat;
    logic [SUM_W-1:0]      rd_diff;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign full        = r_count[CNT_W-1];

    // window test and coordinate mapping for an add
    assign ws     = $signed({2'b00, r_window});
    assign xs     = {i_pos_x[POS_W-1], i_pos_x};
    assign ys     = {i_pos_y[POS_W-1], i_pos_y};
    assign in_win = (xs > -ws) && (xs < ws) && (ys > -ws) && (ys < ws);
    assign xsum   = xs + ws;
    assign ysum   = {r_py[POS_W-1], r_py} + ws;
    assign x_out  = {i_pos_x[POS_W-1], i_pos_x, 3'b000};
    assign y_out  = {i_pos_y[POS_W-1], i_pos_y, 3'b000};
    assign qx_ext = PCO_W'(r_qx);
    assign qy_ext = PCO_W'(div_quo);

    // splat window of the loaded particle
    assign pd_x     = r_part_q[PCO_W-1:0];
    assign pd_y     = r_part_q[2*PCO_W-1:PCO_W];
    assign pd_alive = r_part_q[PW-1];
    assign cxs      = BW'(pd_x >>> 8);
    assign cys      = BW'(pd_y >>> 8);
    assign rs       = $signed(BW'(r_radius));
    assign x0s      = cxs - rs - BW'(1);
    assign x1s      = cxs + rs + BW'(1);
    assign y0s      = cys - rs - BW'(1);
    assign y1s      = cys + rs + BW'(1);
    assign x0c      = (x0s < 0) ? BW'(0) : x0s;
    assign y0c      = (y0s < 0) ? BW'(0) : y0s;
    assign x1c      = (x1s > BW'(IMAGE_SIZE - 1)) ? BW'(IMAGE_SIZE - 1) : x1s;
    assign y1c      = (y1s > BW'(IMAGE_SIZE - 1)) ? BW'(IMAGE_SIZE - 1) : y1s;
    assign empty    = (x0c > x1c) || (y0c > y1c) || !pd_alive;

    // distance to pixel centre, Q.8 offsets, Q.16 squares
    assign dx  = $signed({4'b0000, r_x, 8'h80}) - $signed({r_px_c[PCO_W-1], r_px_c});
    assign dy  = $signed({4'b0000, r_y, 8'h80}) - $signed({r_py_c[PCO_W-1], r_py_c});
    assign dx2 = dx * dx;
    assign dy2 = dy * dy;
    assign d2  = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign rsq = r_radius * r_radius;
    assign lim = (D2W+1)'({rsq, 16'h0000});
    assign in_range = (d2 < lim);

    assign acc     = {1'b0, r_pix_q} + (SUM_W+1)'(r_add);
    assign acc_sat = acc[SUM_W] ? {SUM_W{1'b1}} : acc[SUM_W-1:0];
    assign rd_diff = r_pix_q - r_min;

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        sq_start  = 1'b0;
        sq_rad    = {d2[31:0], 16'h0000};
        case (r_state)
            S_IDLE: begin
                if (accept && t_cmd'(i_cmd) == CMD_ADD && !full && in_win) begin
                    div_start = 1'b1;
                    div_num   = {9'd0, xsum[POS_W-1:0], 16'h0000};
                    div_den   = DIV_DEN_W'(r_window);
                end
            end
            S_DIVX: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_num   = {9'd0, ysum[POS_W-1:0], 16'h0000};
                    div_den   = DIV_DEN_W'(r_window);
                end
            end
            S_CMP: begin
                sq_start = in_range;
            end
            S_SQRT: begin
                if (sq_done) begin
                    div_start = 1'b1;
                    div_num   = DIV_NUM_W'({r_radius, 16'h0000} - sq_root);
                    div_den   = DIV_DEN_W'(r_radius);
                end
            end
            S_RDW: begin
                div_start = 1'b1;
                div_num   = {1'b0, rd_diff, 16'h0000};
                div_den   = r_max - r_min;
            end
            default: begin
            end
        endcase
    end

    // memory port selection
    always_comb begin
        part_we    = 1'b0;
        part_wdata = {r_alive, y_out, x_out};
        pix_we     = 1'b0;
        pix_waddr  = {r_y, r_x};
        pix_wdata  = acc_sat;
        pix_raddr  = {r_y, r_x};
        case (r_state)
            S_IDLE: begin
                pix_raddr  = {i_pixel_row, i_pixel_col};
                part_wdata = {i_alive, y_out, x_out};
                part_we    = accept && t_cmd'(i_cmd) == CMD_ADD && !full && !in_win;
            end
            S_DIVY: begin
                part_wdata = {r_alive, qy_ext, qx_ext};
                part_we    = div_done;
            end
            S_CLEAR: begin
                pix_we    = 1'b1;
                pix_waddr = r_addr;
                pix_wdata = '0;
            end
            S_PRD: begin
                pix_we = 1'b1;
            end
            S_SCAN: begin
                pix_raddr = r_addr;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (part_we) begin
            m_part[r_count[PART_AW-1:0]] <= part_wdata;
        end
        r_part_q <= m_part[r_i[PART_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (pix_we) begin
            m_pix[pix_waddr] <= pix_wdata;
        end
        r_pix_q <= m_pix[pix_raddr];
    end

    psir_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    psir_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (sq_rad),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_radius   <= RADIUS_RST;
            r_window   <= WINDOW_RST;
            r_count    <= '0;
            r_i        <= '0;
            r_rendered <= 1'b0;
            r_min      <= '0;
            r_max      <= '0;
            r_valid    <= 1'b0;
            r_status   <= ST_OK;
            r_intensity <= '0;
            r_addr     <= '0;
            r_scan_v   <= 1'b0;
        end else begin
            r_valid  <= 1'b0;
            r_scan_v <= (r_state == S_SCAN);
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_RADIUS: r_radius <= i_cfg_data[RAD_W-1:0];
                    CFG_WINDOW: r_window <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_scan_v) begin
                if (r_pix_q < r_min) r_min <= r_pix_q;
                if (r_pix_q > r_max) r_max <= r_pix_q;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_status    <= ST_OK;
                        r_intensity <= '0;
                        case (t_cmd'(i_cmd))
                            CMD_ADD: begin
                                if (full) begin
                                    r_status <= ST_FULL;
                                    r_valid  <= 1'b1;
                                end else if (in_win) begin
                                    r_state <= S_DIVX;
                                end else begin
                                    r_count <= r_count + 1'b1;
                                    r_valid <= 1'b1;
                                end
                            end
                            CMD_RENDER: begin
                                r_addr  <= '0;
                                r_state <= S_CLEAR;
                            end
                            CMD_READ: begin
                                if (!r_rendered) begin
                                    r_status <= ST_NOT_REND;
                                    r_valid  <= 1'b1;
                                end else if (r_max == r_min) begin
                                    r_status <= ST_FLAT;
                                    r_valid  <= 1'b1;
                                end else begin
                                    r_state <= S_RDW;
                                end
                            end
                            CMD_CLEAR: begin
                                r_count <= '0;
                                r_valid <= 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_DIVX: begin
                    if (div_done) begin
                        r_state <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (div_done) begin
                        r_count <= r_count + 1'b1;
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (&r_addr) begin
                        r_min <= {SUM_W{1'b1}};
                        r_max <= '0;
                        r_i   <= '0;
                        if (r_radius != '0 && r_count != '0) begin
                            r_state <= S_PLOAD;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_PLOAD: begin
                    r_state <= S_PSET;
                end
                S_PSET: begin
                    r_px_c <= pd_x;
                    r_py_c <= pd_y;
                    r_x0   <= x0c[COORD_W-1:0];
                    r_x1   <= x1c[COORD_W-1:0];
                    r_y1   <= y1c[COORD_W-1:0];
                    r_x    <= x0c[COORD_W-1:0];
                    r_y    <= y0c[COORD_W-1:0];
                    r_state <= empty ? S_NEXTP : S_SQ;
                end
                S_SQ: begin
                    r_dx2   <= $unsigned(dx2);
                    r_dy2   <= $unsigned(dy2);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_state <= in_range ? S_SQRT : S_STEP;
                end
                S_SQRT: begin
                    if (sq_done) begin
                        r_state <= S_DIVC;
                    end
                end
                S_DIVC: begin
                    if (div_done) begin
                        r_add   <= div_quo;
                        r_state <= S_PRD;
                    end
                end
                S_PRD: begin
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (r_x == r_x1) begin
                        r_x <= r_x0;
                        if (r_y == r_y1) begin
                            r_state <= S_NEXTP;
                        end else begin
                            r_y     <= r_y + 1'b1;
                            r_state <= S_SQ;
                        end
                    end else begin
                        r_x     <= r_x + 1'b1;
                        r_state <= S_SQ;
                    end
                end
                S_NEXTP: begin
                    r_i <= r_i + 1'b1;
                    if (r_i + 1'b1 == r_count) begin
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_PLOAD;
                    end
                end
                S_SCAN: begin
                    r_addr <= r_addr + 1'b1;
                    if (&r_addr) begin
                        r_state <= S_SCANE;
                    end
                end
                S_SCANE: begin
                    // last scan word lands this cycle
                    r_rendered <= 1'b1;
                    r_valid    <= 1'b1;
                    r_state    <= S_IDLE;
                end
                S_RDW: begin
                    r_state <= S_RDDIV;
                end
                S_RDDIV: begin
                    if (div_done) begin
                        r_intensity <= div_quo[DIV_Q_W-1] ? {INT_W{1'b1}}
                                                          : div_quo[INT_W-1:0];
                        r_valid     <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept) begin
            r_py    <= i_pos_y;
            r_alive <= i_alive;
        end
        if (r_state == S_DIVX && div_done) begin
            r_qx <= div_quo;
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_intensity = r_intensity;
    assign o_min_sum   = r_min;
    assign o_max_sum   = r_max;

endmodule
